/* hw/rtl/clut_pkg.sv */
// Shared constants, types and anchor tables for the colormap entry generator.
package clut_pkg;

  // Default width of the table entry index.
  localparam int CLUT_INDEX_BITS = 12;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_MAP_SELECT  = 2'd0;
  localparam logic [1:0] REG_LUT_ENTRIES = 2'd1;
  localparam logic [1:0] REG_SPLIT_THR   = 2'd2;

  // Map select codes of the gray ramps, and the number of anchor palettes.
  localparam logic [2:0] MAP_GRAY       = 3'd0;
  localparam logic [2:0] MAP_INV_GRAY   = 3'd6;
  localparam logic [2:0] MAP_SPLIT_GRAY = 3'd7;
  localparam logic [2:0] NUM_PALETTES   = 3'd6;

  // Position one in unsigned Q1.16.
  localparam logic [16:0] POS_ONE = 17'd65536;

  // Nine anchors per palette, each as red, green, blue.
  localparam logic [7:0] ANCHOR [0:5][0:8][0:2] = '{
    '{ '{8'd0,8'd0,8'd0}, '{8'd32,8'd32,8'd32}, '{8'd64,8'd64,8'd64},
       '{8'd96,8'd96,8'd96}, '{8'd128,8'd128,8'd128}, '{8'd160,8'd160,8'd160},
       '{8'd192,8'd192,8'd192}, '{8'd224,8'd224,8'd224}, '{8'd255,8'd255,8'd255} },
    '{ '{8'd0,8'd0,8'd0}, '{8'd60,8'd0,8'd0}, '{8'd120,8'd0,8'd0},
       '{8'd200,8'd30,8'd0}, '{8'd255,8'd90,8'd0}, '{8'd255,8'd150,8'd0},
       '{8'd255,8'd210,8'd40}, '{8'd255,8'd245,8'd140}, '{8'd255,8'd255,8'd255} },
    '{ '{8'd68,8'd1,8'd84}, '{8'd70,8'd50,8'd127}, '{8'd54,8'd92,8'd141},
       '{8'd39,8'd127,8'd142}, '{8'd31,8'd161,8'd135}, '{8'd74,8'd194,8'd109},
       '{8'd159,8'd218,8'd58}, '{8'd220,8'd227,8'd42}, '{8'd253,8'd231,8'd37} },
    '{ '{8'd0,8'd0,8'd4}, '{8'd28,8'd16,8'd68}, '{8'd79,8'd18,8'd123},
       '{8'd129,8'd37,8'd129}, '{8'd181,8'd54,8'd122}, '{8'd229,8'd80,8'd100},
       '{8'd251,8'd135,8'd97}, '{8'd254,8'd194,8'd135}, '{8'd252,8'd253,8'd191} },
    '{ '{8'd0,8'd0,8'd4}, '{8'd31,8'd12,8'd72}, '{8'd85,8'd15,8'd109},
       '{8'd136,8'd34,8'd106}, '{8'd186,8'd54,8'd85}, '{8'd227,8'd89,8'd51},
       '{8'd249,8'd140,8'd10}, '{8'd249,8'd201,8'd50}, '{8'd252,8'd255,8'd164} },
    '{ '{8'd0,8'd32,8'd76}, '{8'd0,8'd42,8'd102}, '{8'd47,8'd68,8'd105},
       '{8'd86,8'd91,8'd105}, '{8'd124,8'd114,8'd106}, '{8'd165,8'd139,8'd99},
       '{8'd208,8'd166,8'd84}, '{8'd247,8'd196,8'd64}, '{8'd255,8'd233,8'd69} }
  };

  // Palette data that rides alongside the split-gray divider.
  typedef struct packed {
    logic [2:0][7:0] a;     // lower anchor per channel
    logic [2:0][7:0] b;     // upper anchor per channel
    logic [13:0]     f;     // fraction in the segment, Q1.13, up to 8192
    logic [7:0]      inv;   // inverted gray level
  } pal_sb_t;

endpackage

/* hw/rtl/colormap_lut_entry_generator_unit.sv */
// Top level of the colormap table entry generator.
//
//  Channel  Direction  Handshake            Payload
//  in_      request    in_valid, in_stall   in_entry_index
//  out_     result     out_valid, out_stall out_red, out_green, out_blue
//  cfg_     write      cfg_we               cfg_index, cfg_wdata
//
// One request enters every cycle while the output is not stalled; a result passes through
// the input register, 17-stage position divider, prep stage, 8-stage split
// divider and two blend stages. Reset clears the valid bits and sets the
// registers to gray, 256 entries and a break at one half. A stall on the
// output freezes the whole pipeline and is passed back as in_stall.
module colormap_lut_entry_generator_unit import clut_pkg::*; #(
  parameter int INDEX_BITS = CLUT_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [INDEX_BITS-1:0] in_entry_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [16:0]           cfg_wdata
);

  localparam int CMP_W = (INDEX_BITS > 13) ? INDEX_BITS : 13;

  logic [2:0]   map_sel_r;
  logic [12:0]  lut_entries_r;
  logic [16:0]  split_thr_r;
  logic         adv;
  logic [12:0]  last;
  logic [12:0]  idx_sat;
  logic         s0_vld_r;
  logic [12:0]  s0_rem_r;
  logic [16:0]  s0_low_r;
  logic [12:0]  s0_den_r;
  logic         pos_vld;
  logic [16:0]  pos;
  logic         pr_vld;
  logic [17:0]  pr_rem;
  logic [7:0]   pr_low;
  logic [17:0]  pr_den;
  pal_sb_t      pr_sb;
  logic         lum_vld;
  logic [7:0]   lum;
  pal_sb_t      lum_sb;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_sel_r     <= MAP_GRAY;
      lut_entries_r <= 13'd256;
      split_thr_r   <= 17'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_SELECT:  map_sel_r     <= cfg_wdata[2:0];
        REG_LUT_ENTRIES: lut_entries_r <= cfg_wdata[12:0];
        REG_SPLIT_THR:   split_thr_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless the output is held.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Saturate the index to the last entry.
  assign last    = (lut_entries_r == '0) ? '0 : lut_entries_r - 13'd1;
  assign idx_sat = (CMP_W'(in_entry_index) > CMP_W'(last)) ? last
                                                            : 13'(in_entry_index);

  // Numerator is idx * 65536 + last / 2, split into remainder and low bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_rem_r <= {1'b0, idx_sat[12:1]};
      s0_low_r <= {idx_sat[0], 4'd0, last[12:1]};
      s0_den_r <= (last == '0) ? 13'd1 : last;
    end
  end

  clut_pdiv #(
    .DEN_W  (13),
    .Q_BITS (17),
    .SB_W   (1)
  ) u_pos_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (s0_vld_r),
    .in_rem  (s0_rem_r),
    .in_low  (s0_low_r),
    .in_den  (s0_den_r),
    .in_sb   (1'b0),
    .out_vld (pos_vld),
    .out_q   (pos),
    .out_sb  ()
  );

  clut_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (pos_vld),
    .in_pos    (pos),
    .map_sel   (map_sel_r),
    .split_thr (split_thr_r),
    .out_vld   (pr_vld),
    .out_rem   (pr_rem),
    .out_low   (pr_low),
    .out_den   (pr_den),
    .out_sb    (pr_sb)
  );

  clut_pdiv #(
    .DEN_W  (18),
    .Q_BITS (8),
    .SB_W   ($bits(pal_sb_t))
  ) u_split_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (pr_vld),
    .in_rem  (pr_rem),
    .in_low  (pr_low),
    .in_den  (pr_den),
    .in_sb   (pr_sb),
    .out_vld (lum_vld),
    .out_q   (lum),
    .out_sb  (lum_sb)
  );

  clut_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (lum_vld),
    .in_lum    (lum),
    .in_sb     (lum_sb),
    .map_sel   (map_sel_r),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

/* hw/rtl/clut_pdiv.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module clut_pdiv #(
  parameter int DEN_W  = 13,
  parameter int Q_BITS = 17,
  parameter int SB_W   = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [Q_BITS-1:0] in_low,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_vld,
  output logic [Q_BITS-1:0] out_q,
  output logic [SB_W-1:0]   out_sb
);

  logic              vld_r [1:Q_BITS];
  logic [DEN_W-1:0]  rem_r [1:Q_BITS];
  logic [DEN_W-1:0]  den_r [1:Q_BITS];
  logic [Q_BITS-1:0] qw_r  [1:Q_BITS];
  logic [SB_W-1:0]   sb_r  [1:Q_BITS];

  // Each stage shifts one numerator bit into the remainder and decides one
  // quotient bit; the quotient fills the word as the numerator leaves it.
  for (genvar k = 1; k <= Q_BITS; k++) begin : g_stg
    logic              s_vld;
    logic [DEN_W-1:0]  s_rem;
    logic [DEN_W-1:0]  s_den;
    logic [Q_BITS-1:0] s_qw;
    logic [SB_W-1:0]   s_sb;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (k == 1) begin : g_first
      assign s_vld = in_vld;
      assign s_rem = in_rem;
      assign s_den = in_den;
      assign s_qw  = in_low;
      assign s_sb  = in_sb;
    end else begin : g_next
      assign s_vld = vld_r[k-1];
      assign s_rem = rem_r[k-1];
      assign s_den = den_r[k-1];
      assign s_qw  = qw_r[k-1];
      assign s_sb  = sb_r[k-1];
    end

    assign trial = {s_rem, s_qw[Q_BITS-1]};
    assign take  = trial >= {1'b0, s_den};
    assign diff  = trial - {1'b0, s_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        qw_r[k]  <= {s_qw[Q_BITS-2:0], take};
        den_r[k] <= s_den;
        sb_r[k]  <= s_sb;
      end
    end
  end

  assign out_vld = vld_r[Q_BITS];
  assign out_q   = qw_r[Q_BITS];
  assign out_sb  = sb_r[Q_BITS];

endmodule

/* hw/rtl/clut_prep.sv */
// Stage that turns a position into split-gray divider inputs and palette data.
module clut_prep import clut_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [16:0] in_pos,
  input  logic [2:0]  map_sel,
  input  logic [16:0] split_thr,
  output logic        out_vld,
  output logic [17:0] out_rem,
  output logic [7:0]  out_low,
  output logic [17:0] out_den,
  output pal_sb_t     out_sb
);

  logic [16:0] brk;
  logic [16:0] gap;
  logic [16:0] span;
  logic [24:0] num255;
  logic [24:0] num2;
  logic [2:0]  seg;
  logic [3:0]  seg_hi;
  logic [2:0]  pal;
  logic [16:0] inv_pos;
  logic [24:0] inv_prod;
  logic [24:0] inv_rnd;
  pal_sb_t     sb_nxt;

  // Split gray: distance from the break and the span it is scaled over.
  assign brk = (split_thr > POS_ONE) ? POS_ONE : split_thr;

  always_comb begin
    if (in_pos >= brk) begin
      if (brk == POS_ONE) begin
        gap  = '0;
        span = 17'd1;
      end else begin
        gap  = in_pos - brk;
        span = POS_ONE - brk;
      end
    end else begin
      gap  = brk - in_pos;
      span = brk;
    end
  end

  // Rounded quotient is (2*d*255 + span) / (2*span).
  assign num255 = {gap, 8'd0} - {8'd0, gap};
  assign num2   = {num255[23:0], 1'b0} + {8'd0, span};

  // Palette segment, fraction and anchors.
  assign seg    = in_pos[16] ? 3'd7 : in_pos[15:13];
  assign seg_hi = {1'b0, seg} + 4'd1;
  assign pal    = (map_sel < NUM_PALETTES) ? map_sel : MAP_GRAY;

  // Inverted gray is a falling ramp with rounding.
  assign inv_pos  = POS_ONE - in_pos;
  assign inv_prod = {inv_pos, 8'd0} - {8'd0, inv_pos};
  assign inv_rnd  = inv_prod + 25'd32768;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sb_nxt.a[c] = ANCHOR[pal][seg][c];
      sb_nxt.b[c] = ANCHOR[pal][seg_hi][c];
    end
    sb_nxt.f   = in_pos[16] ? 14'd8192 : {1'b0, in_pos[12:0]};
    sb_nxt.inv = inv_rnd[23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem <= {1'b0, num2[24:8]};
      out_low <= num2[7:0];
      out_den <= {span, 1'b0};
      out_sb  <= sb_nxt;
    end
  end

endmodule

/* hw/rtl/clut_blend.sv */
// Palette interpolation and final color selection, two register stages.
module clut_blend import clut_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_vld,
  input  logic [7:0] in_lum,
  input  pal_sb_t    in_sb,
  input  logic [2:0] map_sel,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic signed [23:0] acc_nxt [0:2];
  logic signed [23:0] acc_r   [0:2];
  logic               vld_r;
  logic [7:0]         lum_r;
  logic [7:0]         inv_r;
  logic [7:0]         chan   [0:2];

  // Interpolate a + (b - a) * f with a half-step offset for rounding.
  always_comb begin
    logic signed [8:0]  slope;
    logic signed [23:0] prod;
    for (int c = 0; c < 3; c++) begin
      slope      = $signed({1'b0, in_sb.b[c]}) - $signed({1'b0, in_sb.a[c]});
      prod       = 24'(slope * $signed({1'b0, in_sb.f}));
      acc_nxt[c] = $signed({3'd0, in_sb.a[c], 13'd0}) + prod + 24'sd4096;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      lum_r <= in_lum;
      inv_r <= in_sb.inv;
    end
  end

  // Pick the gray ramps or the interpolated palette.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (map_sel)
        MAP_INV_GRAY:   chan[c] = inv_r;
        MAP_SPLIT_GRAY: chan[c] = lum_r;
        default:        chan[c] = acc_r[c][20:13];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red   <= chan[0];
      out_green <= chan[1];
      out_blue  <= chan[2];
    end
  end

endmodule
